[hdl/read_gap_quality_stats_top_defines.svh]
// Assertion macros for the read gap/quality statistics block.
// Used by read_gap_quality_stats_top.sv; no other dependencies.
`ifndef READ_GAP_QUALITY_STATS_TOP_DEFINES_SVH
`define READ_GAP_QUALITY_STATS_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, held off during reset
`define RGQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RGQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rgq_pkg.sv]
// Shared types, codes and constants of the read gap/quality statistics block.
// No dependencies; every other source file but the defines header imports it.
`default_nettype none

package rgq_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int HIST_BINS_DEF   = 51;

    localparam int BASE_W      = 3;
    localparam int QUAL_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CNT_FIELD_W = 24;
    localparam int SFIELD_W    = 25;
    localparam int BIN_FIELD_W = 6;
    localparam int WIDE_W      = 34;   // holds any signed count difference

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTIG = 1'd1;
    localparam logic [QUAL_W-1:0]      CUTOFF_RST     = 8'd40;
    localparam logic [CNT_FIELD_W-1:0] MIN_CONTIG_RST = 24'd8000;

    localparam logic [BASE_W-1:0] BASE_A     = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C     = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G     = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T     = 3'd3;
    localparam logic [BASE_W-1:0] BASE_N     = 3'd4;
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd5;

    localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BIN = 2'd2;

    // q/5 for 8-bit q as (q*205)>>10, exact over the whole range
    localparam logic [15:0] DIV5_MUL   = 16'd205;
    localparam int          DIV5_SHIFT = 10;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic                     last_res;
        logic [CNT_FIELD_W-1:0]   run_length;
        logic [BIN_FIELD_W-1:0]   bin_index;
        logic signed [SFIELD_W-1:0] bin_delta;
        logic [CNT_FIELD_W-1:0]   contigs;
        logic [CNT_FIELD_W-1:0]   gap_runs;
        logic [CNT_FIELD_W-1:0]   gap_bases;
        logic [CNT_FIELD_W-1:0]   zero_runs;
        logic [CNT_FIELD_W-1:0]   zero_bases;
        logic signed [SFIELD_W-1:0] low_quality_count;
        logic [CNT_FIELD_W-1:0]   gc_bases;
    } t_result;

    function automatic logic [BIN_FIELD_W-1:0] f_div5(input logic [QUAL_W-1:0] q);
        logic [15:0] prod;
        prod = 16'(q) * DIV5_MUL;
        return prod[DIV5_SHIFT +: BIN_FIELD_W];
    endfunction

endpackage

`default_nettype wire

[hdl/rgq_item_if.sv]
// Input channel: one base word with its quality and end-of-read flag.
// Depends on rgq_pkg.
`default_nettype none

interface rgq_item_if;
    import rgq_pkg::*;

    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [QUAL_W-1:0] quality;
    logic              last;

    modport source (output valid, base, quality, last, input ready);
    modport sink   (input valid, base, quality, last, output ready);
endinterface

`default_nettype wire

[hdl/rgq_result_if.sv]
// Result channel: run records, read summaries and histogram bin deltas.
// Depends on rgq_pkg.
`default_nettype none

interface rgq_result_if;
    import rgq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic                       last_res;
    logic [CNT_FIELD_W-1:0]     run_length;
    logic [BIN_FIELD_W-1:0]     bin_index;
    logic signed [SFIELD_W-1:0] bin_delta;
    logic [CNT_FIELD_W-1:0]     contigs;
    logic [CNT_FIELD_W-1:0]     gap_runs;
    logic [CNT_FIELD_W-1:0]     gap_bases;
    logic [CNT_FIELD_W-1:0]     zero_runs;
    logic [CNT_FIELD_W-1:0]     zero_bases;
    logic signed [SFIELD_W-1:0] low_quality_count;
    logic [CNT_FIELD_W-1:0]     gc_bases;

    modport source (output valid, kind, last_res, run_length, bin_index, bin_delta,
                    contigs, gap_runs, gap_bases, zero_runs, zero_bases,
                    low_quality_count, gc_bases, input ready);
    modport sink   (input valid, kind, last_res, run_length, bin_index, bin_delta,
                    contigs, gap_runs, gap_bases, zero_runs, zero_bases,
                    low_quality_count, gc_bases, output ready);
endinterface

`default_nettype wire

[hdl/rgq_stats.sv]
// Per-read scalar counters: N runs, gaps, contigs, low-quality and GC bases.
// Depends on rgq_pkg.
`default_nettype none

module rgq_stats #(
    parameter int CW = rgq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [rgq_pkg::BASE_W-1:0]     i_base,
    input  logic [rgq_pkg::QUAL_W-1:0]     i_quality,
    input  logic                           i_last,
    input  logic                           i_clear,
    input  logic [rgq_pkg::QUAL_W-1:0]     i_cutoff,
    input  logic [rgq_pkg::CNT_FIELD_W-1:0] i_min_contig,
    output logic                           o_low,
    output logic                           o_rec_valid,
    output rgq_pkg::t_result               o_rec,
    output rgq_pkg::t_result               o_sum,
    output logic                           o_sweep_en,
    output logic [CW-1:0]                  o_gap_bases
);
    import rgq_pkg::*;

    localparam int CMP_W = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;

    function automatic logic [CW-1:0] f_inc(input logic [CW-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    function automatic logic [CW-1:0] f_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    logic              r_at_start;
    logic              r_in_run;
    logic [QUAL_W-1:0] r_run_q;
    logic [CW-1:0]     r_len, r_base, r_contig, r_gruns, r_gbases;
    logic [CW-1:0]     r_zruns, r_zbases, r_low, r_gc;

    logic              is_n, qnz, cont, close1, in_run2;
    logic [CW-1:0]     len2, contig_a, contig1, gr1, gb1, zr1, zb1;
    logic [CW-1:0]     n_contig, n_gruns, n_gbases, n_zruns, n_zbases;

    // a base either extends the open N run or closes it; on the last base the
    // run still open is closed too, then a trailing gap drops one contig
    always_comb begin
        is_n     = (i_base == BASE_N);
        qnz      = |i_quality;
        cont     = is_n && r_in_run && (i_quality == r_run_q);
        close1   = r_in_run && !cont;
        contig_a = r_at_start ? ((is_n && qnz) ? '0 : CW'(1)) : r_contig;

        contig1 = contig_a;
        gr1     = r_gruns;
        gb1     = r_gbases;
        zr1     = r_zruns;
        zb1     = r_zbases;
        if (close1) begin
            if (r_run_q != '0) begin
                contig1 = f_inc(contig_a);
                gr1     = f_inc(r_gruns);
                gb1     = f_add(r_gbases, r_len);
            end else begin
                zr1 = f_inc(r_zruns);
                zb1 = f_add(r_zbases, r_len);
            end
        end
        in_run2 = cont || is_n;
        len2    = cont ? f_inc(r_len) : CW'(1);

        n_contig = contig1;
        n_gruns  = gr1;
        n_gbases = gb1;
        n_zruns  = zr1;
        n_zbases = zb1;
        if (i_last && is_n) begin
            if (qnz) begin
                n_contig = f_inc(contig1);
                n_gruns  = f_inc(gr1);
                n_gbases = f_add(gb1, len2);
                n_contig = (n_contig != '0) ? n_contig - 1'b1 : '0;
            end else begin
                n_zruns  = f_inc(zr1);
                n_zbases = f_add(zb1, len2);
            end
        end
    end

    assign o_low       = (i_quality < i_cutoff);
    assign o_rec_valid = close1;

    always_comb begin
        o_rec            = '0;
        o_rec.kind       = KIND_RUN;
        o_rec.run_length = CNT_FIELD_W'(r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_at_start <= 1'b1;
            r_in_run   <= 1'b0;
            r_run_q    <= '0;
            r_len      <= '0;
            r_base     <= '0;
            r_contig   <= CW'(1);
            r_gruns    <= '0;
            r_gbases   <= '0;
            r_zruns    <= '0;
            r_zbases   <= '0;
            r_low      <= '0;
            r_gc       <= '0;
        end else if (i_accept) begin
            r_at_start <= 1'b0;
            r_base     <= f_inc(r_base);
            if (o_low) begin
                r_low <= f_inc(r_low);
            end
            if (i_base == BASE_C || i_base == BASE_G) begin
                r_gc <= f_inc(r_gc);
            end
            r_contig <= n_contig;
            r_gruns  <= n_gruns;
            r_gbases <= n_gbases;
            r_zruns  <= n_zruns;
            r_zbases <= n_zbases;
            if (is_n) begin
                r_run_q <= i_quality;
            end
            // after the last base r_len keeps the length of a trailing N run, else zero
            r_in_run <= i_last ? 1'b0 : in_run2;
            r_len    <= (i_last && !is_n) ? '0 : len2;
        end
    end

    // summary, read from the settled totals while the read is wound up
    logic signed [CW:0]       low_net;
    logic signed [WIDE_W-1:0] low_wide;
    logic [CW-1:0]            non_gap;

    assign low_net  = signed'({1'b0, r_low}) - signed'({1'b0, r_gbases});
    assign low_wide = WIDE_W'(low_net);
    assign non_gap  = r_base - r_gbases;

    always_comb begin
        o_sum                   = '0;
        o_sum.kind              = KIND_SUM;
        o_sum.run_length        = CNT_FIELD_W'(r_len);
        o_sum.contigs           = CNT_FIELD_W'(r_contig);
        o_sum.gap_runs          = CNT_FIELD_W'(r_gruns);
        o_sum.gap_bases         = CNT_FIELD_W'(r_gbases);
        o_sum.zero_runs         = CNT_FIELD_W'(r_zruns);
        o_sum.zero_bases        = CNT_FIELD_W'(r_zbases);
        o_sum.low_quality_count = low_wide[SFIELD_W-1:0];
        o_sum.gc_bases          = CNT_FIELD_W'(r_gc);
    end

    assign o_sweep_en  = (CMP_W'(non_gap) >= CMP_W'(i_min_contig));
    assign o_gap_bases = r_gbases;

endmodule

`default_nettype wire

[hdl/rgq_hist.sv]
// Low-quality histogram memory: read-modify-write per low base, sweep read port.
// Depends on rgq_pkg.
`default_nettype none

module rgq_hist #(
    parameter int CW = rgq_pkg::COUNT_WIDTH_DEF,
    parameter int HB = rgq_pkg::HIST_BINS_DEF,
    parameter int BW = (HB > 1) ? $clog2(HB) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_upd,
    input  logic [rgq_pkg::QUAL_W-1:0] i_quality,
    input  logic                       i_sweep_rd,
    input  logic [BW-1:0]              i_sweep_addr,
    input  logic                       i_clear,
    output logic [CW-1:0]              o_rd_data,
    output logic                       o_busy
);
    import rgq_pkg::*;

    logic [CW-1:0]      mem [HB];
    logic [HB-1:0]      r_vld;
    logic [CW-1:0]      r_rd_raw;
    logic               r_rd_vld;
    logic               r_s1_v, r_s1_hit;
    logic [BW-1:0]      r_s1_bin;
    logic [CW-1:0]      r_fwd;

    logic [BIN_FIELD_W-1:0] q_div;
    logic [BW-1:0]          bin_in, rd_addr;
    logic                   rd_en;
    logic [CW-1:0]          rmw_old, rmw_new;

    assign q_div   = f_div5(i_quality);
    assign bin_in  = (int'(q_div) >= HB) ? BW'(HB - 1) : BW'(q_div);
    assign rd_en   = i_upd || i_sweep_rd;
    assign rd_addr = i_sweep_rd ? i_sweep_addr : bin_in;

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;
    assign o_busy    = r_s1_v;

    // back-to-back updates of one bin take the value just computed
    assign rmw_old = r_s1_hit ? r_fwd : o_rd_data;
    assign rmw_new = (rmw_old == '1) ? rmw_old : rmw_old + 1'b1;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_raw <= mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (r_s1_v) begin
            mem[r_s1_bin] <= rmw_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bin <= bin_in;
        r_fwd    <= rmw_new;
        r_s1_hit <= i_upd && r_s1_v && (r_s1_bin == bin_in);
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (r_s1_v) begin
            r_vld[r_s1_bin] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[hdl/rgq_outq.sv]
// Two-word output queue driving the result channel.
// Depends on rgq_pkg and rgq_result_if.
`default_nettype none

module rgq_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rgq_pkg::t_result i_data,
    output logic             o_space,
    rgq_result_if.source     o_result
);
    import rgq_pkg::*;

    t_result      r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         pop;
    t_result      head;

    assign head    = r_q[r_rp];
    assign pop     = o_result.valid && o_result.ready;
    assign o_space = (r_cnt != 2'd2);

    assign o_result.valid             = (r_cnt != 2'd0);
    assign o_result.kind              = head.kind;
    assign o_result.last_res          = head.last_res;
    assign o_result.run_length        = head.run_length;
    assign o_result.bin_index         = head.bin_index;
    assign o_result.bin_delta         = head.bin_delta;
    assign o_result.contigs           = head.contigs;
    assign o_result.gap_runs          = head.gap_runs;
    assign o_result.gap_bases         = head.gap_bases;
    assign o_result.zero_runs         = head.zero_runs;
    assign o_result.zero_bases        = head.zero_bases;
    assign o_result.low_quality_count = head.low_quality_count;
    assign o_result.gc_bases          = head.gc_bases;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

[hdl/read_gap_quality_stats_top.sv]
// Top level of the read gap/quality statistics block: config, sequencing, assertions.
// Depends on rgq_pkg, rgq_item_if, rgq_result_if, rgq_stats, rgq_hist, rgq_outq
// and read_gap_quality_stats_top_defines.svh.
//
//  channel    dir  handshake        word
//  i_item     in   valid/ready      base, quality, last
//  o_result   out  valid/ready      kind, last_res, run_length, bin_index, bin_delta,
//                                   contigs .. gc_bases
//  i_cfg_*    in   write enable     register index, data (no read-back)
//
// One base per cycle while the result queue has room; a base gives at most one
// run record. After a base with last set, input stalls for the summary word and,
// when the histogram bins are swept out of the memory (one bin per cycle through
// its single read port while the result side takes them), for the sweep as well.
// Reset is synchronous; histogram entries carry valid bits, so no clearing pass.
`default_nettype none

module read_gap_quality_stats_top #(
    parameter int COUNT_WIDTH = rgq_pkg::COUNT_WIDTH_DEF,
    parameter int HIST_BINS   = rgq_pkg::HIST_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rgq_item_if.sink                      i_item,
    rgq_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [rgq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rgq_pkg::*;

`include "read_gap_quality_stats_top_defines.svh"

    localparam int BW    = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int CNT_W = $clog2(HIST_BINS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;   // taking bases
    localparam logic [1:0] ST_SUM   = 2'd1;   // summary word pending
    localparam logic [1:0] ST_SWEEP = 2'd2;   // streaming histogram deltas

    // configuration registers
    logic [QUAL_W-1:0]      r_cutoff;
    logic [CNT_FIELD_W-1:0] r_min_contig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff     <= CUTOFF_RST;
            r_min_contig <= MIN_CONTIG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CUTOFF:     r_cutoff     <= i_cfg_data[QUAL_W-1:0];
                CFG_MIN_CONTIG: r_min_contig <= i_cfg_data[CNT_FIELD_W-1:0];
            endcase
        end
    end

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_issue_cnt;
    logic             r_sw_v;
    logic [BW-1:0]    r_sw_idx;

    logic             in_acc, is_low, rec_valid, sweep_en, hist_busy;
    logic             q_push, q_space, sw_rd, push_bin, rd_clear;
    t_result          rec_word, sum_word, bin_word, q_word;
    logic [COUNT_WIDTH-1:0] gap_bases, hist_data;

    assign i_item.ready = (r_state == ST_IDLE) && q_space;
    assign in_acc       = i_item.valid && i_item.ready;

    rgq_stats #(.CW(COUNT_WIDTH)) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_acc),
        .i_base       (i_item.base),
        .i_quality    (i_item.quality),
        .i_last       (i_item.last),
        .i_clear      (rd_clear),
        .i_cutoff     (r_cutoff),
        .i_min_contig (r_min_contig),
        .o_low        (is_low),
        .o_rec_valid  (rec_valid),
        .o_rec        (rec_word),
        .o_sum        (sum_word),
        .o_sweep_en   (sweep_en),
        .o_gap_bases  (gap_bases)
    );

    // sweep reads wait until the last base's histogram write has landed
    assign sw_rd    = (r_state == ST_SWEEP) && (r_issue_cnt != CNT_W'(HIST_BINS))
                      && !hist_busy && (!r_sw_v || push_bin);
    assign push_bin = (r_state == ST_SWEEP) && r_sw_v && q_space;

    rgq_hist #(.CW(COUNT_WIDTH), .HB(HIST_BINS), .BW(BW)) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (in_acc && is_low),
        .i_quality    (i_item.quality),
        .i_sweep_rd   (sw_rd),
        .i_sweep_addr (r_issue_cnt[BW-1:0]),
        .i_clear      (rd_clear),
        .o_rd_data    (hist_data),
        .o_busy       (hist_busy)
    );

    // bin delta; bin 0 gives back the gap bases
    logic signed [COUNT_WIDTH:0] delta;
    logic signed [WIDE_W-1:0]    delta_wide;
    logic                        last_bin;

    assign last_bin   = (r_sw_idx == BW'(HIST_BINS - 1));
    assign delta      = signed'({1'b0, hist_data})
                        - ((r_sw_idx == '0) ? signed'({1'b0, gap_bases}) : '0);
    assign delta_wide = WIDE_W'(delta);

    always_comb begin
        bin_word           = '0;
        bin_word.kind      = KIND_BIN;
        bin_word.last_res  = last_bin;
        bin_word.bin_index = BIN_FIELD_W'(r_sw_idx);
        bin_word.bin_delta = delta_wide[SFIELD_W-1:0];
    end

    // sequencer: one word into the queue per cycle at most
    always_comb begin
        n_state  = r_state;
        q_push   = 1'b0;
        q_word   = rec_word;
        rd_clear = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                q_push = in_acc && rec_valid;
                if (in_acc && i_item.last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                q_word          = sum_word;
                q_word.last_res = !sweep_en;
                if (q_space) begin
                    q_push = 1'b1;
                    if (sweep_en) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state  = ST_IDLE;
                        rd_clear = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                q_word = bin_word;
                q_push = push_bin;
                if (push_bin && last_bin) begin
                    n_state  = ST_IDLE;
                    rd_clear = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue_cnt <= '0;
            r_sw_v      <= 1'b0;
            r_sw_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SUM) begin
                r_issue_cnt <= '0;
            end else if (sw_rd) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
            end
            if (sw_rd) begin
                r_sw_v   <= 1'b1;
                r_sw_idx <= r_issue_cnt[BW-1:0];
            end else if (push_bin) begin
                r_sw_v <= 1'b0;
            end
        end
    end

    rgq_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_word),
        .o_space  (q_space),
        .o_result (o_result)
    );

    // a last base always leads into the summary; other bases keep the block open
    `RGQ_ASSERT_NEXT(a_last_to_sum, i_clk, i_rst_n, in_acc && i_item.last, r_state == ST_SUM, "last base did not start read wind-up")
    `RGQ_ASSERT_NEXT(a_mid_stays_idle, i_clk, i_rst_n, in_acc && !i_item.last, r_state == ST_IDLE, "block left idle mid-read")
    // the queue never overflows
    `RGQ_ASSERT_SAME(a_push_space, i_clk, i_rst_n, q_push, q_space, "result queue overrun")
    // only the top bin closes a read with a delta word
    `RGQ_ASSERT_SAME(a_last_bin, i_clk, i_rst_n, o_result.valid && o_result.kind == KIND_BIN && o_result.last_res, o_result.bin_index == BIN_FIELD_W'(HIST_BINS - 1), "read ended on a bin other than the top one")

endmodule

`default_nettype wire

[tb/sv/read_gap_quality_stats_check.sv]
// Result predictor and comparator for read_gap_quality_stats_top.
// Watches the base, result and register-write ports; depends on rgq_pkg,
// rgq_item_if and rgq_result_if.
module read_gap_quality_stats_check
    import rgq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgq_item_if                   i_item,
    rgq_result_if                 i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CW    = COUNT_WIDTH_DEF;
    localparam int     NBINS = HIST_BINS_DEF;
    localparam longint SMAX  = (longint'(1) << CW) - 1;
    localparam longint SMIN  = -SMAX - 1;

    // register copies
    logic [QUAL_W-1:0] cutoff_q;
    logic [CW-1:0]     min_bases_q;

    // per-read totals
    logic              fresh_read;
    logic              in_nrun;
    logic [QUAL_W-1:0] nrun_qual;
    logic [CW-1:0]     nrun_len;
    logic [CW-1:0]     bases_seen;
    logic [CW-1:0]     contig_cnt;
    logic [CW-1:0]     gap_run_cnt;
    logic [CW-1:0]     gap_base_cnt;
    logic [CW-1:0]     zero_run_cnt;
    logic [CW-1:0]     zero_base_cnt;
    logic [CW-1:0]     low_cnt;
    logic [CW-1:0]     gc_cnt;
    logic [CW-1:0]     low_hist [NBINS];

    t_result due_words [$];
    int      word_idx;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    function automatic logic signed [SFIELD_W-1:0] clamp_signed(input longint v);
        if (v > SMAX) v = SMAX;
        if (v < SMIN) v = SMIN;
        return v[SFIELD_W-1:0];
    endfunction

    function automatic void clear_read_totals();
        in_nrun       = 1'b0;
        nrun_qual     = '0;
        nrun_len      = '0;
        bases_seen    = '0;
        contig_cnt    = CW'(1);
        gap_run_cnt   = '0;
        gap_base_cnt  = '0;
        zero_run_cnt  = '0;
        zero_base_cnt = '0;
        low_cnt       = '0;
        gc_cnt        = '0;
        for (int i = 0; i < NBINS; i++) low_hist[i] = '0;
    endfunction

    // a nonzero-quality run is a gap and opens another contig
    function automatic void close_nrun();
        if (nrun_qual != 0) begin
            contig_cnt   = sat_add(contig_cnt, CW'(1));
            gap_run_cnt  = sat_add(gap_run_cnt, CW'(1));
            gap_base_cnt = sat_add(gap_base_cnt, nrun_len);
        end else begin
            zero_run_cnt  = sat_add(zero_run_cnt, CW'(1));
            zero_base_cnt = sat_add(zero_base_cnt, nrun_len);
        end
        in_nrun = 1'b0;
    endfunction

    function automatic void tally_base(input logic [BASE_W-1:0] b, input logic [QUAL_W-1:0] q,
                                       input logic l);
        t_result     w;
        int          bin;
        logic        is_n;
        logic        emit;
        logic [CW-1:0] tail_len;
        logic [63:0] nongap;
        longint      d;
        is_n = (b == BASE_N);
        if (fresh_read) begin
            clear_read_totals();
            fresh_read = 1'b0;
            if (is_n && q != 0) contig_cnt = '0;   // leading gap
        end
        bases_seen = sat_add(bases_seen, CW'(1));
        if (q < cutoff_q) begin
            bin = int'(q) / 5;
            if (bin >= NBINS) bin = NBINS - 1;
            low_cnt       = sat_add(low_cnt, CW'(1));
            low_hist[bin] = sat_add(low_hist[bin], CW'(1));
        end
        if (b == BASE_C || b == BASE_G) gc_cnt = sat_add(gc_cnt, CW'(1));

        if (is_n && in_nrun && q == nrun_qual) begin
            nrun_len = sat_add(nrun_len, CW'(1));
        end else begin
            if (in_nrun) begin
                w            = '0;
                w.kind       = KIND_RUN;
                w.run_length = nrun_len;
                due_words.push_back(w);
                close_nrun();
            end
            if (is_n) begin
                in_nrun   = 1'b1;
                nrun_qual = q;
                nrun_len  = CW'(1);
            end
        end

        if (l) begin
            tail_len = '0;
            if (in_nrun) begin
                tail_len = nrun_len;
                close_nrun();
            end
            // trailing gap, never below zero
            if (is_n && q != 0 && contig_cnt != 0) contig_cnt = contig_cnt - 1'b1;
            nongap = 64'(bases_seen) - 64'(gap_base_cnt);
            emit   = (nongap >= 64'(min_bases_q));

            w                   = '0;
            w.kind              = KIND_SUM;
            w.last_res          = !emit;
            w.run_length        = tail_len;
            w.contigs           = contig_cnt;
            w.gap_runs          = gap_run_cnt;
            w.gap_bases         = gap_base_cnt;
            w.zero_runs         = zero_run_cnt;
            w.zero_bases        = zero_base_cnt;
            w.low_quality_count = clamp_signed(longint'(low_cnt) - longint'(gap_base_cnt));
            w.gc_bases          = gc_cnt;
            due_words.push_back(w);

            if (emit) begin
                for (int i = 0; i < NBINS; i++) begin
                    d = longint'(low_hist[i]);
                    if (i == 0) d = d - longint'(gap_base_cnt);
                    w           = '0;
                    w.kind      = KIND_BIN;
                    w.last_res  = (i == NBINS - 1);
                    w.bin_index = BIN_FIELD_W'(i);
                    w.bin_delta = clamp_signed(d);
                    due_words.push_back(w);
                end
            end
            fresh_read = 1'b1;
        end
    endfunction

    function automatic string field_diff(input t_result e, input t_result g);
        string s;
        s = "";
        if (e.kind !== g.kind)                           s = {s, " kind"};
        if (e.last_res !== g.last_res)                   s = {s, " last_res"};
        if (e.run_length !== g.run_length)               s = {s, " run_length"};
        if (e.bin_index !== g.bin_index)                 s = {s, " bin_index"};
        if (e.bin_delta !== g.bin_delta)                 s = {s, " bin_delta"};
        if (e.contigs !== g.contigs)                     s = {s, " contigs"};
        if (e.gap_runs !== g.gap_runs)                   s = {s, " gap_runs"};
        if (e.gap_bases !== g.gap_bases)                 s = {s, " gap_bases"};
        if (e.zero_runs !== g.zero_runs)                 s = {s, " zero_runs"};
        if (e.zero_bases !== g.zero_bases)               s = {s, " zero_bases"};
        if (e.low_quality_count !== g.low_quality_count) s = {s, " low_quality_count"};
        if (e.gc_bases !== g.gc_bases)                   s = {s, " gc_bases"};
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        string   diff;
        if (!i_rst_n) begin
            cutoff_q    = CUTOFF_RST;
            min_bases_q = MIN_CONTIG_RST;
            clear_read_totals();
            fresh_read = 1'b1;
            due_words.delete();
            word_idx     = 0;
            o_fail_count = 0;
        end else begin
            // a base taken on a write edge still sees the old register value
            if (i_item.valid && i_item.ready)
                tally_base(i_item.base, i_item.quality, i_item.last);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CUTOFF) cutoff_q = i_cfg_data[QUAL_W-1:0];
                else if (i_cfg_idx == CFG_MIN_CONTIG) min_bases_q = i_cfg_data[CW-1:0];
            end
            if (i_result.valid && i_result.ready) begin
                got.kind              = i_result.kind;
                got.last_res          = i_result.last_res;
                got.run_length        = i_result.run_length;
                got.bin_index         = i_result.bin_index;
                got.bin_delta         = i_result.bin_delta;
                got.contigs           = i_result.contigs;
                got.gap_runs          = i_result.gap_runs;
                got.gap_bases         = i_result.gap_bases;
                got.zero_runs         = i_result.zero_runs;
                got.zero_bases        = i_result.zero_bases;
                got.low_quality_count = i_result.low_quality_count;
                got.gc_bases          = i_result.gc_bases;
                if (due_words.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("[%0t] result word %0d with nothing due: %p", $time, word_idx, got);
                end else begin
                    want = due_words.pop_front();
                    diff = field_diff(want, got);
                    if (diff != "") begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("[%0t] result word %0d differs in%s\n  expected %p\n  actual   %p",
                                     $time, word_idx, diff, want, got);
                    end
                end
                word_idx = word_idx + 1;
            end
        end
        o_pending = due_words.size();
    end

endmodule

[tb/sv/read_gap_quality_stats_top_tb.sv]
// Testbench top for read_gap_quality_stats_top: clock, reset, base stimulus,
// result back-pressure, register writes and the verdict.
// Depends on rgq_pkg, rgq_item_if, rgq_result_if and read_gap_quality_stats_check.
module read_gap_quality_stats_top_tb;
    import rgq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS        = HIST_BINS_DEF;
    localparam int DRAIN_CYCLES = NBINS + 8;     // bin sweep plus summary, with margin
    localparam int LONG_HOLD    = 400;           // receiver hold-off that backs up the block
    localparam int CYCLE_LIMIT  = 2000000;       // above a run with every base sweeping bins at full stalls
    localparam int PHASE_WORDS  = 50;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_cnt = 0;

    // pacing knobs shared by the sender (main process) and the receiver
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    rgq_item_if   item_ch ();
    rgq_result_if result_ch ();

    read_gap_quality_stats_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    read_gap_quality_stats_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a result that never shows up ends here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one base word. Valid drops only for a drawn gap; with no gap it stays
    // high straight into the next word, so valid never gets two updates in a step.
    // Returns at the edge where the word was taken.
    task automatic send_base(input logic [BASE_W-1:0] b, input logic [QUAL_W-1:0] q,
                             input logic l);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.base    <= b;
        item_ch.quality <= q;
        item_ch.last    <= l;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Stop offering, wait for every due word, then give the block time to finish
    // any bin sweep or run bookkeeping that produces no word we track.
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers on back-to-back edges; write enable stays high across them.
    task automatic program_regs(input logic [QUAL_W-1:0] cutoff,
                                input logic [CNT_FIELD_W-1:0] min_bases);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CUTOFF;
        cfg_data <= CFG_DATA_W'(cutoff);
        @(posedge i_clk);
        cfg_idx  <= CFG_MIN_CONTIG;
        cfg_data <= CFG_DATA_W'(min_bases);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // One read of random content. N bases come in runs that often share a
    // quality, so gap and zero runs of several bases form. About a tenth of the
    // words are noise over the full field ranges (base codes 5..7 included).
    // A read cut short by the budget carries no last flag and is continued by
    // the next phase after a register write.
    task automatic send_random_read(inout int budget);
        int                len;
        bit                full;
        logic [BASE_W-1:0] b;
        logic [QUAL_W-1:0] q;
        logic              prev_n;
        logic [QUAL_W-1:0] prev_q;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        full = (len <= budget);
        if (!full) len = budget;
        tx_steady = ($urandom_range(0, 5) == 0);
        rx_steady = ($urandom_range(0, 5) == 0);
        prev_n = 1'b0;
        prev_q = '0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                b = $urandom_range(0, 7);
                q = $urandom_range(0, 255);
            end else if ($urandom_range(0, 99) < 45) begin
                b = BASE_N;
                if (prev_n && $urandom_range(0, 2) != 0) q = prev_q;
                else if ($urandom_range(0, 2) == 0)     q = '0;
                else                                    q = $urandom_range(0, 255);
            end else begin
                b = $urandom_range(0, 3);
                q = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 255);
            end
            prev_n = (b == BASE_N);
            prev_q = q;
            send_base(b, q, full && (i == len - 1));
            budget = budget - 1;
        end
    endtask

    task automatic run_random(input int words);
        int budget;
        budget = words;
        while (budget > 0) send_random_read(budget);
    endtask

    // Result side: per word a drawn stall with ready low, then ready high until a
    // word is taken. Once asked, it holds off for a long stretch so the block
    // fills up and pushes back on the base side.
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    initial begin
        item_ch.valid   <= 1'b0;
        item_ch.base    <= '0;
        item_ch.quality <= '0;
        item_ch.last    <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_CUTOFF;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset settings: cutoff 40, histogram threshold 8000 ---
        // single-base read, summary only
        send_base(BASE_A, 8'd0, 1'b1);
        // zero run, one-base gap, C below cutoff, G at cutoff, trailing gap of two
        send_base(BASE_N, 8'd0, 1'b0);
        send_base(BASE_N, 8'd0, 1'b0);
        send_base(BASE_N, 8'd7, 1'b0);
        send_base(BASE_C, 8'd39, 1'b0);
        send_base(BASE_G, 8'd40, 1'b0);
        send_base(BASE_N, 8'd255, 1'b0);
        send_base(BASE_N, 8'd255, 1'b1);
        // leading gap, then T and the codes that count as "other" (6 and 7 unused)
        send_base(BASE_N, 8'd3, 1'b0);
        send_base(BASE_T, 8'd10, 1'b0);
        send_base(3'd6, 8'd20, 1'b0);
        send_base(3'd7, 8'd255, 1'b0);
        send_base(BASE_OTHER, 8'd0, 1'b1);
        settle();

        // --- directed, cutoff at max and no threshold: every read sweeps bins ---
        program_regs(8'd255, 24'd0);
        // top bin qualities inside a gap, bin 0 brought to zero by gap bases
        send_base(BASE_N, 8'd254, 1'b0);
        send_base(BASE_N, 8'd250, 1'b0);
        send_base(BASE_A, 8'd0, 1'b0);
        send_base(BASE_C, 8'd4, 1'b1);
        // read that is one gap base: leading and trailing gap together
        send_base(BASE_N, 8'd1, 1'b1);
        // read ending in a zero-quality run
        send_base(BASE_G, 8'd254, 1'b0);
        send_base(BASE_N, 8'd0, 1'b0);
        send_base(BASE_N, 8'd0, 1'b1);
        // quality 255 is never below any cutoff
        send_base(BASE_T, 8'd128, 1'b0);
        send_base(BASE_N, 8'd255, 1'b1);
        settle();

        // --- random phases, one register setting each ---
        program_regs(8'd0, 24'hFF_FFFF);
        run_random(PHASE_WORDS);
        settle();
        program_regs(8'($urandom), 24'($urandom_range(0, 24)));
        run_random(PHASE_WORDS);
        settle();
        hold_req = 1'b1;
        program_regs(8'd255, 24'd0);
        run_random(PHASE_WORDS);
        settle();
        program_regs(8'($urandom), 24'($urandom_range(0, 40)));
        run_random(PHASE_WORDS);
        settle();
        program_regs(CUTOFF_RST, MIN_CONTIG_RST);
        run_random(PHASE_WORDS);
        settle();
        program_regs(8'($urandom), 24'($urandom_range(0, 12)));
        run_random(PHASE_WORDS);
        settle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/rgq_pkg.sv
hdl/rgq_item_if.sv
hdl/rgq_result_if.sv
hdl/rgq_stats.sv
hdl/rgq_hist.sv
hdl/rgq_outq.sv
hdl/read_gap_quality_stats_top.sv
tb/sv/read_gap_quality_stats_check.sv
tb/sv/read_gap_quality_stats_top_tb.sv
